>>> hdl/md5bc_pkg.sv
// ----------------------------------------------------------------------------
// md5bc_pkg
// Types, constants and round helpers shared by the MD5 compression core.
// ----------------------------------------------------------------------------
package md5bc_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5bc_vars_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [31:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // message word index for a round
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] r4;
    logic [3:0] idx;
    r4 = rnd[3:0];
    case (rnd[5:4])
      2'd0:    idx = r4;
      2'd1:    idx = r4 * 4'd5 + 4'd1;
      2'd2:    idx = r4 * 4'd3 + 4'd5;
      2'd3:    idx = r4 * 4'd7;
      default: idx = r4;
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

endpackage

>>> hdl/md5bc_round.sv
// ----------------------------------------------------------------------------
// md5bc_round
// One MD5 round: round function, constant and message add, rotate, shuffle.
// ----------------------------------------------------------------------------
module md5bc_round
  import md5bc_pkg::*;
(
  input  logic [5:0]  rnd,
  input  logic [31:0] msg,
  input  md5bc_vars_t cur,
  output md5bc_vars_t nxt
);

  logic [31:0] f;
  logic [31:0] sum;

  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (cur.b & cur.c) | (~cur.b & cur.d);
      2'd1:    f = (cur.d & cur.b) | (~cur.d & cur.c);
      2'd2:    f = cur.b ^ cur.c ^ cur.d;
      2'd3:    f = cur.c ^ (cur.b | ~cur.d);
      default: f = cur.b ^ cur.c ^ cur.d;
    endcase
  end

  assign sum   = f + cur.a + RoundK[rnd] + msg;
  assign nxt.a = cur.d;
  assign nxt.b = cur.b + rotl32(sum, rot_amount(rnd));
  assign nxt.c = cur.b;
  assign nxt.d = cur.c;

endmodule

>>> hdl/md5_block_compression_core.sv
// ----------------------------------------------------------------------------
// md5_block_compression_core
// MD5 compression over a stream of padded 32-bit message words.
// ----------------------------------------------------------------------------
// Message words are taken one per cycle while msg_stall is low and written
// into a 16-entry block memory. The sixteenth word starts the compression:
// one round unit runs the 64 rounds, one per cycle, reading each round's
// message word from the block memory ahead of that round (single read
// port, registered read data), and the fold state then adds the result
// into the chaining value. The round loop sets the pace of a full block;
// msg_stall is high while compressing, folding or sending. A word with
// message_end set is followed by the four digest words a, b, c, d
// (digest_last on d), after which the chaining value returns to the MD5
// initial vector. An end inside a partial block drops the partial block and
// sends the current chaining value.
// ----------------------------------------------------------------------------
module md5_block_compression_core
  import md5bc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [31:0] message_word,
  input  logic        message_end,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_word,
  output logic        digest_last
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_COMP = 4'b0010,
    ST_FOLD = 4'b0100,
    ST_SEND = 4'b1000
  } state_t;

  state_t      state;
  logic [3:0]  pos;          // next write slot in the block
  logic [5:0]  rnd;          // current round
  logic [1:0]  sel;          // digest word being sent
  logic        end_pending;  // block finished by a final word
  logic [31:0] cv [4];       // chaining value
  md5bc_vars_t vars;         // working a, b, c, d
  md5bc_vars_t vars_next;

  // block memory, read data registered
  logic [31:0] blk_mem [16];
  logic [3:0]  raddr;
  logic [31:0] rdata;

  logic msg_take;
  logic dig_take;

  assign msg_stall    = (state != ST_IDLE);
  assign msg_take     = msg_valid && !msg_stall;
  assign digest_valid = (state == ST_SEND);
  assign dig_take     = digest_valid && !digest_stall;
  assign digest_word  = cv[sel];
  assign digest_last  = (sel == 2'd3);

  // prefetch: round 0 uses word 0, round r uses the word fetched during r-1
  assign raddr = (state == ST_COMP) ? msg_index(rnd + 6'd1) : 4'd0;

  always_ff @(posedge clk) begin
    if (msg_take) begin
      blk_mem[pos] <= message_word;
    end
    rdata <= blk_mem[raddr];
  end

  md5bc_round u_round (
    .rnd (rnd),
    .msg (rdata),
    .cur (vars),
    .nxt (vars_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pos         <= '0;
      rnd         <= '0;
      sel         <= '0;
      end_pending <= 1'b0;
      cv[0]       <= IV_A;
      cv[1]       <= IV_B;
      cv[2]       <= IV_C;
      cv[3]       <= IV_D;
      vars        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (msg_take) begin
            end_pending <= message_end;
            if (pos == 4'd15) begin
              // block complete: seed working vars and run the rounds
              pos    <= '0;
              rnd    <= '0;
              vars.a <= cv[0];
              vars.b <= cv[1];
              vars.c <= cv[2];
              vars.d <= cv[3];
              state  <= ST_COMP;
            end else if (message_end) begin
              // partial block is dropped
              pos   <= '0;
              sel   <= '0;
              state <= ST_SEND;
            end else begin
              pos <= pos + 4'd1;
            end
          end
        end
        ST_COMP: begin
          vars <= vars_next;
          rnd  <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          cv[0] <= cv[0] + vars.a;
          cv[1] <= cv[1] + vars.b;
          cv[2] <= cv[2] + vars.c;
          cv[3] <= cv[3] + vars.d;
          sel   <= '0;
          state <= end_pending ? ST_SEND : ST_IDLE;
        end
        ST_SEND: begin
          if (dig_take) begin
            sel <= sel + 2'd1;
            if (sel == 2'd3) begin
              cv[0] <= IV_A;
              cv[1] <= IV_B;
              cv[2] <= IV_C;
              cv[3] <= IV_D;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/md5bc_checker.sv
// ----------------------------------------------------------------------------
// md5bc_checker
// Port-level checks for the MD5 compression core, bound to the top level.
// ----------------------------------------------------------------------------
module md5bc_checker (
  input logic        clk,
  input logic        rst,
  input logic        msg_valid,
  input logic        msg_stall,
  input logic        message_end,
  input logic        digest_valid,
  input logic        digest_stall,
  input logic [31:0] digest_word,
  input logic        digest_last
);

  // no new word is taken while a digest is going out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> msg_stall)
    else $error("word accepted while digest pending");

  // a final word always blocks further input on the next cycle
  a_end_blocks: assert property (@(posedge clk) disable iff (rst)
    (msg_valid && !msg_stall && message_end) |=> msg_stall)
    else $error("input open right after final word");

  // the digest stops after its last word is taken
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && !digest_stall && digest_last) |=> !digest_valid)
    else $error("digest continues past last word");

  // stalled digest word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && digest_stall) |=>
      (digest_valid && $stable(digest_word) && $stable(digest_last)))
    else $error("stalled digest word changed");

endmodule

bind md5_block_compression_core md5bc_checker u_md5bc_checker (
  .clk          (clk),
  .rst          (rst),
  .msg_valid    (msg_valid),
  .msg_stall    (msg_stall),
  .message_end  (message_end),
  .digest_valid (digest_valid),
  .digest_stall (digest_stall),
  .digest_word  (digest_word),
  .digest_last  (digest_last)
);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MD5 block compression core.
// ----------------------------------------------------------------------------
// Message words go in on a valid/stall channel. Digest words come out on a
// second valid/stall channel and are scored in order against an MD5
// predictor kept in this file. The directed table covers the extremes, an
// end word right after reset, the empty-message known answer and an end
// inside a partial block. The random part that follows is mostly well-formed
// messages of one to three blocks, mixed with messages that end mid-block.
// Both channels idle and stall at random, except during one quiet stretch.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Run length limits, in clock cycles (RANDOM_WORDS in message words)
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 200;   // longer than one block pass
  localparam int unsigned RANDOM_WORDS = 150;

  // MD5 initial chaining value and per-round left-rotate amounts
  localparam logic [31:0] MD5_INIT [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };
  localparam int unsigned ROT_LEFT [4][4] = '{
    '{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}
  };

  typedef struct {
    logic [31:0] word;
    logic        last;
  } digest_t;

  // One row of the directed table; known[] holds a typed-in digest
  typedef struct {
    logic [31:0] word;
    logic        fin;
    bit          typed;
    logic [31:0] known [4];
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        msg_valid = 1'b0;
  logic        msg_stall;
  logic [31:0] message_word = '0;
  logic        message_end = 1'b0;
  logic        digest_valid;
  logic        digest_stall = 1'b0;
  logic [31:0] digest_word;
  logic        digest_last;

  // Predictor state: chaining value, block buffer, fill position
  logic [31:0] hash_state [4];
  logic [31:0] block_words [16];
  int unsigned fill_pos;
  logic [31:0] sine_k [64];

  digest_t     digest_q [$];
  digest_t     digest_head;
  stim_row_t   stim_rows [$];

  bit          calm = 1'b0;   // quiet stretch: no idling on either side
  int unsigned fail_count = 0;
  int unsigned words_checked = 0;
  int unsigned blocks_done = 0;
  int unsigned messages_done = 0;
  int unsigned partial_ends = 0;
  int unsigned cycle_count = 0;

  md5_block_compression_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .message_word (message_word),
    .message_end  (message_end),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest_word  (digest_word),
    .digest_last  (digest_last)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  // Round constants are rebuilt from the sine definition, not copied.
  function automatic void build_sine_table();
    real    sv;
    longint kv;
    for (int i = 0; i < 64; i++) begin
      sv = $sin(i + 1.0);
      if (sv < 0.0) sv = -sv;
      kv = longint'($floor(sv * 4294967296.0));
      sine_k[i] = kv[31:0];
    end
  endfunction

  // 64 rounds over block_words, folded into hash_state
  function automatic void compress_md5_block();
    logic [31:0] va, vb, vc, vd, fx, hold;
    int unsigned g, s;
    va = hash_state[0];
    vb = hash_state[1];
    vc = hash_state[2];
    vd = hash_state[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          fx = (vb & vc) | (~vb & vd);
          g  = r;
        end
        1: begin
          fx = (vd & vb) | (~vd & vc);
          g  = (5 * r + 1) % 16;
        end
        2: begin
          fx = vb ^ vc ^ vd;
          g  = (3 * r + 5) % 16;
        end
        default: begin
          fx = vc ^ (vb | ~vd);
          g  = (7 * r) % 16;
        end
      endcase
      fx   = fx + va + sine_k[r] + block_words[g];
      s    = ROT_LEFT[r / 16][r % 4];
      hold = vd;
      vd   = vc;
      vc   = vb;
      vb   = vb + ((fx << s) | (fx >> (32 - s)));
      va   = hold;
    end
    hash_state[0] += va;
    hash_state[1] += vb;
    hash_state[2] += vc;
    hash_state[3] += vd;
  endfunction

  // Absorb one accepted word; returns 1 when it closes a message.
  function automatic bit md5_absorb(input logic [31:0] w, input logic fin,
                                    output logic [31:0] dig [4]);
    block_words[fill_pos] = w;
    if (fill_pos == 15) begin
      compress_md5_block();
      blocks_done++;
      fill_pos = 0;
    end else begin
      fill_pos++;
      if (fin) partial_ends++;   // partial block is dropped
    end
    if (!fin) return 1'b0;
    dig = hash_state;
    hash_state = MD5_INIT;
    fill_pos = 0;
    messages_done++;
    return 1'b1;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------

  task automatic add_row(input logic [31:0] w, input logic fin, input bit typed,
                         input logic [31:0] known [4]);
    stim_row_t row;
    row.word  = w;
    row.fin   = fin;
    row.typed = typed;
    row.known = known;
    stim_rows.push_back(row);
  endtask

  // Present one word, hold it through any stall, then queue the digest of a message it closes.
  task automatic feed_word(input logic [31:0] w, input logic fin, input bit typed,
                           input logic [31:0] known [4]);
    logic [31:0] dig [4];
    while (!calm && $urandom_range(0, 99) < 16) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_valid    <= 1'b1;
    message_word <= w;
    message_end  <= fin;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    if (md5_absorb(w, fin, dig)) begin
      for (int k = 0; k < 4; k++) begin
        digest_q.push_back(digest_t'{word: typed ? known[k] : dig[k], last: (k == 3)});
      end
    end
  endtask

  // Random word, biased toward the all-zero and all-one extremes
  function automatic logic [31:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'h0000_0000;
    if (sel == 1) return 32'hffff_ffff;
    return $urandom;
  endfunction

  // -------------------------------------------------------------------------
  // Result side: random stall, in-order scoreboard
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    digest_stall <= !rst && !calm && ($urandom_range(0, 99) < 16);
  end

  always @(posedge clk) begin
    if (!rst && digest_valid && !digest_stall) begin
      if (digest_q.size() == 0) begin
        $error("digest word 0x%08h with no digest pending", digest_word);
        fail_count++;
      end else begin
        digest_head = digest_q.pop_front();
        words_checked++;
        if (digest_word !== digest_head.word) begin
          $error("digest_word: expected 0x%08h, got 0x%08h",
                 digest_head.word, digest_word);
          fail_count++;
        end
        if (digest_last !== digest_head.last) begin
          $error("digest_last: expected %0b, got %0b", digest_head.last, digest_last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d digest words still pending",
             cycle_count, digest_q.size());
    $display("md5_block_compression_core regression: fail");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    logic [31:0] none [4];
    logic [31:0] empty_md5 [4];
    int unsigned sent;
    int unsigned nblk;
    int unsigned tail;

    none      = '{default: '0};
    // MD5 of the empty message, as little-endian words a, b, c, d
    empty_md5 = '{32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec};

    build_sine_table();
    hash_state  = MD5_INIT;
    block_words = '{default: '0};
    fill_pos    = 0;

    // Directed table.
    // End on the very first word after reset: partial block dropped, IV out.
    add_row(32'hffff_ffff, 1'b1, 1'b1, MD5_INIT);
    // Back-to-back end: chaining value was reloaded, so IV again
    add_row(32'h0000_0000, 1'b1, 1'b1, MD5_INIT);
    // Empty message, padded: 0x80 byte, zeros, zero bit length
    add_row(32'h0000_0080, 1'b0, 1'b0, none);
    for (int i = 1; i < 15; i++) add_row(32'h0, 1'b0, 1'b0, none);
    add_row(32'h0, 1'b1, 1'b1, empty_md5);
    // End inside a partial block of extreme words: nothing compressed, IV out
    add_row(32'hffff_ffff, 1'b0, 1'b0, none);
    add_row(32'h0000_0000, 1'b0, 1'b0, none);
    add_row(32'h8000_0001, 1'b0, 1'b0, none);
    add_row(32'h7fff_fffe, 1'b1, 1'b1, MD5_INIT);

    // Hold reset, then release it
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      feed_word(stim_rows[i].word, stim_rows[i].fin, stim_rows[i].typed,
                stim_rows[i].known);
    end

    // Random messages. Most are well formed (whole blocks, end on the last
    // word); about one in five ends inside a block after up to two full blocks.
    // A quiet stretch with no idling sits in the middle.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      calm = (sent >= 60 && sent < 110);
      nblk = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
      if ($urandom_range(0, 4) == 0) begin
        nblk = $urandom_range(0, 2);
        tail = $urandom_range(0, 14);
      end else begin
        tail = 16;  // marks a clean end on the block boundary
      end
      for (int b = 0; b < nblk; b++) begin
        for (int i = 0; i < 16; i++) begin
          feed_word(pick_word(), (tail == 16 && b == nblk - 1 && i == 15),
                    1'b0, none);
          sent++;
        end
      end
      if (tail != 16) begin
        for (int i = 0; i < tail; i++) begin
          feed_word(pick_word(), 1'b0, 1'b0, none);
          sent++;
        end
        feed_word(pick_word(), 1'b1, 1'b0, none);
        sent++;
      end
    end
    calm = 1'b0;
    msg_valid <= 1'b0;

    // Drain, then give the core time to show any stray output
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d messages (%0d ending mid-block), %0d blocks compressed",
             messages_done, partial_ends, blocks_done);
    $display("checked %0d digest words in %0d cycles", words_checked, cycle_count);
    if (fail_count == 0) begin
      $display("md5_block_compression_core regression: pass");
    end else begin
      $display("md5_block_compression_core regression: fail");
    end
    $finish;
  end

endmodule
